[src/prq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready-queue scheduler package
// Field widths, operation and status codes, transaction structs and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int ID_W           = 5;
	localparam int PRIO_W         = 5;
	localparam int OP_W           = 3;
	localparam int STATUS_W       = 2;
	localparam int DEF_NUM_TASKS  = 32;
	localparam int DEF_NUM_LEVELS = 32;

	localparam logic [OP_W-1:0] OP_READY  = 3'd0;
	localparam logic [OP_W-1:0] OP_YIELD  = 3'd1;
	localparam logic [OP_W-1:0] OP_BLOCK  = 3'd2;
	localparam logic [OP_W-1:0] OP_SWITCH = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_RUN = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] task_prio;
	} sched_item_t;

	typedef struct packed {
		logic                switch_request;
		logic [ID_W-1:0]     run_task_id;
		logic [PRIO_W-1:0]   run_task_prio;
		logic                task_changed;
		logic [STATUS_W-1:0] status;
	} sched_result_t;

	typedef struct packed {
		logic                load;
		logic                enq_rd;
		logic                enq_wr;
		logic                src_run;
		logic                find;
		logic                rd_ht;
		logic                rd_link;
		logic                pop;
		logic                block;
		logic                set_req;
		logic                set_status;
		logic [STATUS_W-1:0] status;
		logic                finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            id_ok;
		logic            running;
		logic            ready;
		logic            preempt;
		logic            found;
		logic            better;
	} dp_stat_t;

endpackage
`default_nettype wire

[src/prq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready-queue scheduler controller
// Sequences each command through the enqueue, level search and dequeue
// steps of the datapath that it needs.
// ----------------------------------------------------------------------------
module prq_ctrl
	import prq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ENQ_RD,
		S_ENQ_WR,
		S_FIND,
		S_TICK_CHK,
		S_RD_HT,
		S_RD_LINK,
		S_POP,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   src_q;
	logic   src_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		src_d   = src_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_READY: begin
						if (stat.id_ok) begin
							src_d   = 1'b0;
							state_d = S_ENQ_RD;
						end else begin
							state_d = S_FINISH;
						end
					end
					OP_YIELD: begin
						cmd.set_req = 1'b1;
						if (stat.running) begin
							src_d   = 1'b1;
							state_d = S_ENQ_RD;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = STAT_NO_RUN;
							state_d        = S_FINISH;
						end
					end
					OP_BLOCK: begin
						if (stat.running) begin
							cmd.block   = 1'b1;
							cmd.set_req = 1'b1;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = STAT_NO_RUN;
						end
						state_d = S_FINISH;
					end
					OP_SWITCH: begin
						if (stat.running) begin
							src_d   = 1'b1;
							state_d = S_ENQ_RD;
						end else begin
							state_d = S_FIND;
						end
					end
					OP_TICK: begin
						if (stat.running) begin
							state_d = S_FIND;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = STAT_NO_RUN;
							state_d        = S_FINISH;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_ENQ_RD: begin
				cmd.enq_rd  = 1'b1;
				cmd.src_run = src_q;
				state_d     = S_ENQ_WR;
			end
			S_ENQ_WR: begin
				cmd.enq_wr  = 1'b1;
				cmd.src_run = src_q;
				if (!src_q) begin
					if (stat.running && stat.preempt) begin
						cmd.set_req = 1'b1;
						src_d       = 1'b1;
						state_d     = S_ENQ_RD;
					end else begin
						state_d = S_FINISH;
					end
				end else if (stat.op == OP_SWITCH) begin
					state_d = S_FIND;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = (stat.op == OP_SWITCH) ? S_RD_HT : S_TICK_CHK;
			end
			S_TICK_CHK: begin
				if (stat.found && stat.better) begin
					src_d   = 1'b1;
					state_d = S_ENQ_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RD_HT: begin
				if (stat.found) begin
					cmd.rd_ht = 1'b1;
					state_d   = S_RD_LINK;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = STAT_EMPTY;
					state_d        = S_FINISH;
				end
			end
			S_RD_LINK: begin
				cmd.rd_link = 1'b1;
				state_d     = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				if (stat.op == OP_TICK && stat.ready) begin
					cmd.set_req = 1'b1;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			src_q   <= src_d;
		end
	end

endmodule
`default_nettype wire

[src/prq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready-queue scheduler datapath
// Per-level head and tail memories, the task link memory, the non-empty
// level mask, the running task registers and the result register.
// ----------------------------------------------------------------------------
module prq_datapath
	import prq_pkg::*;
#(
	parameter int NUM_TASKS  = DEF_NUM_TASKS,
	parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sched_item_t item,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	output logic             done,
	output sched_result_t    result
);

	localparam int LVL_W  = $clog2(NUM_LEVELS);
	localparam int TIDX_W = $clog2(NUM_TASKS);

	typedef enum logic [1:0] {
		RS_NONE,
		RS_RUNNING,
		RS_READY,
		RS_BLOCKED
	} run_state_t;

	logic [ID_W-1:0] head_mem [NUM_LEVELS];
	logic [ID_W-1:0] tail_mem [NUM_LEVELS];
	logic [ID_W-1:0] link_mem [NUM_TASKS];

	logic [NUM_LEVELS-1:0] mask_q;
	logic [ID_W-1:0]       run_id_q;
	logic [LVL_W-1:0]      run_prio_q;
	run_state_t            run_state_q;
	logic                  done_q;

	logic [OP_W-1:0]     op_q;
	logic [ID_W-1:0]     id_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                id_ok_q;
	logic [ID_W-1:0]     prev_id_q;
	logic                prev_none_q;
	logic                req_q;
	logic [STATUS_W-1:0] status_q;
	logic                changed_q;
	logic [LVL_W-1:0]    best_q;
	logic                found_q;
	logic [ID_W-1:0]     rd_head_q;
	logic [ID_W-1:0]     rd_tail_q;
	logic [ID_W-1:0]     rd_link_q;
	sched_result_t       result_q;

	logic [LVL_W-1:0]      sat_lvl;
	logic [NUM_LEVELS-1:0] low_bit;
	logic [LVL_W-1:0]      best_lvl;
	logic [LVL_W-1:0]      enq_lvl;
	logic [ID_W-1:0]       enq_id;
	logic [LVL_W-1:0]      tail_raddr;

	assign sat_lvl = (int'(item.task_prio) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
		: LVL_W'(item.task_prio);

	assign low_bit = mask_q & (~mask_q + NUM_LEVELS'(1));

	always_comb begin
		best_lvl = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (low_bit[i]) begin
				best_lvl = best_lvl | LVL_W'(i);
			end
		end
	end

	assign enq_lvl    = cmd.src_run ? run_prio_q : lvl_q;
	assign enq_id     = cmd.src_run ? run_id_q : id_q;
	assign tail_raddr = cmd.rd_ht ? best_q : enq_lvl;

	assign stat.op      = op_q;
	assign stat.id_ok   = id_ok_q;
	assign stat.running = (run_state_q == RS_RUNNING);
	assign stat.ready   = (run_state_q == RS_READY);
	assign stat.preempt = (lvl_q < run_prio_q);
	assign stat.found   = found_q;
	assign stat.better  = (best_q < run_prio_q);

	always_ff @(posedge clk) begin
		if (cmd.enq_wr && !mask_q[enq_lvl]) begin
			head_mem[enq_lvl] <= enq_id;
		end else if (cmd.pop && (rd_head_q != rd_tail_q)) begin
			head_mem[best_q] <= rd_link_q;
		end
		if (cmd.rd_ht) begin
			rd_head_q <= head_mem[best_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_wr) begin
			tail_mem[enq_lvl] <= enq_id;
		end
		if (cmd.enq_rd || cmd.rd_ht) begin
			rd_tail_q <= tail_mem[tail_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_wr && mask_q[enq_lvl]) begin
			link_mem[TIDX_W'(rd_tail_q)] <= enq_id;
		end
		if (cmd.rd_link) begin
			rd_link_q <= link_mem[TIDX_W'(rd_head_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			run_id_q    <= '0;
			run_prio_q  <= '0;
			run_state_q <= RS_NONE;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.enq_wr) begin
				mask_q[enq_lvl] <= 1'b1;
				if (cmd.src_run) begin
					run_state_q <= RS_READY;
				end
			end
			if (cmd.block) begin
				run_state_q <= RS_BLOCKED;
			end
			if (cmd.pop) begin
				if (rd_head_q == rd_tail_q) begin
					mask_q[best_q] <= 1'b0;
				end
				run_id_q    <= rd_head_q;
				run_prio_q  <= best_q;
				run_state_q <= RS_RUNNING;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= item.operation;
			id_q        <= item.task_id;
			lvl_q       <= sat_lvl;
			id_ok_q     <= (int'(item.task_id) < NUM_TASKS);
			prev_id_q   <= run_id_q;
			prev_none_q <= (run_state_q == RS_NONE);
			req_q       <= 1'b0;
			status_q    <= STAT_OK;
			changed_q   <= 1'b0;
		end
		if (cmd.set_req) begin
			req_q <= 1'b1;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.find) begin
			best_q  <= best_lvl;
			found_q <= |mask_q;
		end
		if (cmd.pop) begin
			changed_q <= prev_none_q || (rd_head_q != prev_id_q);
		end
		if (cmd.finish) begin
			result_q.switch_request <= req_q | cmd.set_req;
			result_q.run_task_id    <= run_id_q;
			result_q.run_task_prio  <= PRIO_W'(run_prio_q);
			result_q.task_changed   <= changed_q;
			result_q.status         <= status_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[src/priority_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority ready-queue scheduler
// A command runs from acceptance to its result strobe through the controller
// states: each enqueue reads the tail memory and then writes the queue, and a
// switch adds a level search, a head and tail read, a link read and the
// dequeue update. A new command may start in the cycle the result strobe shows.
// Reset empties every level and leaves no task running; the queue memories
// are not cleared, since the non-empty mask guards every read that matters.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
	import prq_pkg::*;
#(
	parameter int NUM_TASKS  = DEF_NUM_TASKS,
	parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire sched_item_t item,
	output logic             done,
	output sched_result_t    result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	prq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	prq_datapath #(
		.NUM_TASKS  (NUM_TASKS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

[src/prq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready-queue scheduler port checker
// Checks the command and result timing and result consistency at the ports.
// ----------------------------------------------------------------------------
module prq_checker
	import prq_pkg::*;
(
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire sched_result_t result
);

	// A result never shows while a transaction is still in progress.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A task change only comes from a successful dequeue.
	a_changed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.task_changed) |-> (result.status == STAT_OK))
		else $error("task change reported with a failing status");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
